// File: hdl/age_pkg.sv
// Shared types, constants and helper functions for the articulation gain envelope.
package age_pkg;

  // Gain is unsigned Q1.15: one integer bit above the fraction bits.
  localparam int GAIN_FRAC_BITS = 15;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1) << GAIN_FRAC_BITS;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE              = 3'd0,
    REG_PITCH_GRACE_COUNT   = 3'd1,
    REG_UNVOICED_HOLD_COUNT = 3'd2,
    REG_ATTACK_STEP         = 3'd3,
    REG_RELEASE_STEP        = 3'd4,
    REG_ONSET_FLOOR         = 3'd5,
    REG_UNVOICED_FLOOR      = 3'd6
  } cfg_reg_e;

  // Item action codes.
  localparam logic ACT_BEGIN  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef struct packed {
    logic             enable;
    logic [CFG_W-1:0] pitch_grace_count;
    logic [CFG_W-1:0] unvoiced_hold_count;
    logic [CFG_W-1:0] attack_step;
    logic [CFG_W-1:0] release_step;
    logic [CFG_W-1:0] onset_floor;
    logic [CFG_W-1:0] unvoiced_floor;
  } cfg_t;

  typedef struct packed {
    logic action;
    logic target_ok;
    logic voiced;
    logic onset;
  } in_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              keep_active;
  } out_t;

  function automatic logic [GAIN_W-1:0] sat_unity(input logic [CFG_W-1:0] v);
    return (v > CFG_W'(UNITY)) ? UNITY : GAIN_W'(v);
  endfunction

  // Zero step still moves by one LSB.
  function automatic logic [GAIN_W-1:0] usable_step(input logic [CFG_W-1:0] s);
    return (s == '0) ? GAIN_W'(1) : sat_unity(s);
  endfunction

endpackage

// File: hdl/age_cfg.sv
// Configuration register file for the articulation gain envelope.
module age_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_en,
  input  logic [age_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [age_pkg::CFG_W-1:0]     cfg_data,
  output age_pkg::cfg_t                 cfg
);
  import age_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable              <= 1'b0;
      cfg.pitch_grace_count   <= '0;
      cfg.unvoiced_hold_count <= '0;
      cfg.attack_step         <= CFG_W'(UNITY);
      cfg.release_step        <= CFG_W'(UNITY);
      cfg.onset_floor         <= '0;
      cfg.unvoiced_floor      <= '0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_ENABLE:              cfg.enable              <= cfg_data[0];
        REG_PITCH_GRACE_COUNT:   cfg.pitch_grace_count   <= cfg_data;
        REG_UNVOICED_HOLD_COUNT: cfg.unvoiced_hold_count <= cfg_data;
        REG_ATTACK_STEP:         cfg.attack_step         <= cfg_data;
        REG_RELEASE_STEP:        cfg.release_step        <= cfg_data;
        REG_ONSET_FLOOR:         cfg.onset_floor         <= cfg_data;
        REG_UNVOICED_FLOOR:      cfg.unvoiced_floor      <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

// File: hdl/age_step.sv
// Envelope state and the combinational gain and hold-counter update.
module age_step #(
  parameter int HOLD_COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  age_pkg::in_t  item,
  input  age_pkg::cfg_t cfg,
  output age_pkg::out_t result
);
  import age_pkg::*;

  logic [GAIN_W-1:0]          gain_level, gain_level_next;
  logic [HOLD_COUNT_BITS-1:0] pitch_hold_left, pitch_hold_left_next;
  logic [HOLD_COUNT_BITS-1:0] unvoiced_hold_left, unvoiced_hold_left_next;

  logic [GAIN_W-1:0] onset_fl, unvoiced_fl, target, step, diff, move;
  logic              hold_any, rise;

  always_comb begin
    onset_fl    = sat_unity(cfg.onset_floor);
    unvoiced_fl = sat_unity(cfg.unvoiced_floor);
    hold_any    = (pitch_hold_left != '0) || (unvoiced_hold_left != '0);

    target = item.target_ok ? UNITY : '0;
    if (item.onset && onset_fl > target) target = onset_fl;
    // Unvoiced: hold the gain up while a hold still runs, else fall to the floor.
    if (!item.voiced) begin
      if (hold_any) target = (gain_level > unvoiced_fl) ? gain_level : unvoiced_fl;
      else          target = unvoiced_fl;
    end

    rise = target > gain_level;
    step = rise ? usable_step(cfg.attack_step) : usable_step(cfg.release_step);
    diff = rise ? (target - gain_level) : (gain_level - target);
    move = (diff < step) ? diff : step;

    gain_level_next         = gain_level;
    pitch_hold_left_next    = pitch_hold_left;
    unvoiced_hold_left_next = unvoiced_hold_left;

    if (item.action == ACT_SAMPLE) begin
      gain_level_next = rise ? (gain_level + move) : (gain_level - move);
      if (pitch_hold_left != '0)
        pitch_hold_left_next = pitch_hold_left - HOLD_COUNT_BITS'(1);
      if (unvoiced_hold_left != '0)
        unvoiced_hold_left_next = unvoiced_hold_left - HOLD_COUNT_BITS'(1);
    end else begin
      if (item.target_ok)
        pitch_hold_left_next = HOLD_COUNT_BITS'(cfg.pitch_grace_count);
      if (item.voiced)
        unvoiced_hold_left_next = HOLD_COUNT_BITS'(cfg.unvoiced_hold_count);
    end

    result.gain        = gain_level_next;
    result.keep_active = cfg.enable &&
                         ((pitch_hold_left_next != '0) || (unvoiced_hold_left_next != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_level         <= '0;
      pitch_hold_left    <= '0;
      unvoiced_hold_left <= '0;
    end else if (advance) begin
      gain_level         <= gain_level_next;
      pitch_hold_left    <= pitch_hold_left_next;
      unvoiced_hold_left <= unvoiced_hold_left_next;
    end
  end

endmodule

// File: hdl/articulation_gain_envelope.sv
// Per-sample gain envelope: input register, envelope update, result register.
//
// Input channel in_valid/in_stall/in_data carries one item: a begin-block
// reload (action 0) or one sample (action 1). Output channel
// out_valid/out_stall/out_data returns exactly one gain/keep_active result
// per item, in order. An item transfers at an edge where valid is high and
// stall is low.
// The item lands in the input register at its transfer edge; the result
// register captures it once out_valid is low or out_stall is low, so
// out_valid rises after that capture and the result can then transfer out.
// Throughput: one item per cycle while out_stall stays low; the gain and
// hold counters update combinationally between input and result register.
// When the receiver stalls, the result register holds its result and the
// input register can still take one more item; in_stall rises only while
// both registers are full and out_stall is high.
// Reset (rst, synchronous) empties both registers, clears gain and hold
// counters, and returns configuration to its reset values. Configuration
// writes (cfg_en, cfg_index, cfg_data) take effect the next cycle; the
// user must make them while no item is in flight; this is not enforced.
module articulation_gain_envelope #(
  parameter int HOLD_COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  age_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output age_pkg::out_t                 out_data,
  input  logic                          cfg_en,
  input  logic [age_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [age_pkg::CFG_W-1:0]     cfg_data
);
  import age_pkg::*;

  cfg_t cfg;
  in_t  item;
  out_t result;
  logic item_valid, item_valid_next, out_valid_next;
  logic advance, in_take;

  age_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  age_step #(
    .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    item_valid_next = item_valid;
    if (in_take)      item_valid_next = 1'b1;
    else if (advance) item_valid_next = 1'b0;

    out_valid_next = out_valid;
    if (advance)         out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) item <= in_data;
    if (advance) out_data <= result;
  end

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.gain <= UNITY)
    else $error("gain above unity");

  a_keep_needs_enable: assert property (@(posedge clk) disable iff (rst)
    advance |-> (!result.keep_active || cfg.enable))
    else $error("keep_active while disabled");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost on advance");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!out_valid && !item_valid))
    else $error("registers not empty after reset");

endmodule

// File: verif/tb_articulation_gain_envelope.sv
// Self-checking testbench for the articulation gain envelope: directed and random traffic.
module tb_articulation_gain_envelope;
  import age_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Envelope state and register copy kept by the testbench.
  cfg_t shadow;
  logic [GAIN_W-1:0] env_gain;
  logic [15:0] grace_left;
  logic [15:0] hold_left;

  out_t pending_gains[$];
  out_t oldest;
  int mismatches = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  articulation_gain_envelope uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_en(cfg_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic out_t advance_envelope(input in_t item);
    int unsigned goal;
    int unsigned onset_min;
    int unsigned unv_min;
    int unsigned step;
    int unsigned gap;
    logic [CFG_W-1:0] raw_step;
    out_t res;
    if (item.action == ACT_BEGIN) begin
      if (item.target_ok) grace_left = shadow.pitch_grace_count;
      if (item.voiced) hold_left = shadow.unvoiced_hold_count;
    end else begin
      goal = item.target_ok ? UNITY : 0;
      onset_min = (shadow.onset_floor > UNITY) ? UNITY : shadow.onset_floor;
      unv_min = (shadow.unvoiced_floor > UNITY) ? UNITY : shadow.unvoiced_floor;
      if (item.onset && onset_min > goal) goal = onset_min;
      // Unvoiced: keep at least the current gain while either counter still runs.
      if (!item.voiced) begin
        if (grace_left != 0 || hold_left != 0)
          goal = (env_gain > unv_min) ? env_gain : unv_min;
        else
          goal = unv_min;
      end
      raw_step = (goal > env_gain) ? shadow.attack_step : shadow.release_step;
      step = (raw_step == 0) ? 1 : ((raw_step > UNITY) ? UNITY : raw_step);
      if (goal > env_gain) begin
        gap = goal - env_gain;
        env_gain = env_gain + GAIN_W'((gap < step) ? gap : step);
      end else begin
        gap = env_gain - goal;
        env_gain = env_gain - GAIN_W'((gap < step) ? gap : step);
      end
      if (grace_left != 0) grace_left--;
      if (hold_left != 0) hold_left--;
    end
    res.gain = env_gain;
    res.keep_active = shadow.enable && (grace_left != 0 || hold_left != 0);
    return res;
  endfunction

  task automatic log_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Check results, predict on each input transfer, and run the watchdog.
  always @(posedge clk) begin
    if (rst) begin
      env_gain = '0;
      grace_left = '0;
      hold_left = '0;
      shadow = '{enable: 1'b0, pitch_grace_count: '0, unvoiced_hold_count: '0,
                 attack_step: UNITY, release_step: UNITY, onset_floor: '0,
                 unvoiced_floor: '0};
      quiet_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_gains.size() == 0) begin
          log_mismatch($sformatf("result with nothing expected, gain %0d", out_data.gain));
        end else begin
          oldest = pending_gains.pop_front();
          if (out_data.gain !== oldest.gain)
            log_mismatch($sformatf("gain got %0d expected %0d", out_data.gain, oldest.gain));
          if (out_data.keep_active !== oldest.keep_active)
            log_mismatch($sformatf("keep_active got %b expected %b",
                                   out_data.keep_active, oldest.keep_active));
        end
      end
      if (in_valid && !in_stall) pending_gains.push_back(advance_envelope(in_data));
      if ((out_valid && !out_stall) || (in_valid && !in_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("articulation_gain_envelope test failed");
        $finish;
      end
    end
  end

  task automatic send_item(input in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_flags(input logic act, input logic ok, input logic vcd,
                            input logic ons);
    in_t item;
    item.action = act;
    item.target_ok = ok;
    item.voiced = vcd;
    item.onset = ons;
    send_item(item);
  endtask

  // Drop valid and wait until every expected result has transferred.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_gains.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_ENABLE:              shadow.enable = val[0];
      REG_PITCH_GRACE_COUNT:   shadow.pitch_grace_count = val;
      REG_UNVOICED_HOLD_COUNT: shadow.unvoiced_hold_count = val;
      REG_ATTACK_STEP:         shadow.attack_step = val;
      REG_RELEASE_STEP:        shadow.release_step = val;
      REG_ONSET_FLOOR:         shadow.onset_floor = val;
      REG_UNVOICED_FLOOR:      shadow.unvoiced_floor = val;
      default: ;
    endcase
  endtask

  task automatic program_envelope(input logic en, input logic [CFG_W-1:0] grace,
                                  input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] rise,
                                  input logic [CFG_W-1:0] fall,
                                  input logic [CFG_W-1:0] onset_min,
                                  input logic [CFG_W-1:0] unv_min);
    wait_drained();
    cfg_write(REG_ENABLE, CFG_W'(en));
    cfg_write(REG_PITCH_GRACE_COUNT, grace);
    cfg_write(REG_UNVOICED_HOLD_COUNT, hold);
    cfg_write(REG_ATTACK_STEP, rise);
    cfg_write(REG_RELEASE_STEP, fall);
    cfg_write(REG_ONSET_FLOOR, onset_min);
    cfg_write(REG_UNVOICED_FLOOR, unv_min);
    cfg_en <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_step();
    case ($urandom_range(9))
      0: return '0;
      1: return CFG_W'(1);
      2: return UNITY;
      3: return '1;
      4: return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_floor();
    case ($urandom_range(7))
      0: return '0;
      1: return UNITY;
      2: return '1;
      3: return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(0, UNITY));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_hold();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic test_reset_values();
    send_flags(ACT_SAMPLE, 1'b1, 1'b1, 1'b0);
    send_flags(ACT_BEGIN, 1'b1, 1'b1, 1'b0);
    send_flags(ACT_SAMPLE, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_unused_index();
    wait_drained();
    cfg_write(REG_UNUSED, '1);
    cfg_en <= 1'b0;
    send_flags(ACT_SAMPLE, 1'b1, 1'b1, 1'b0);
    send_flags(ACT_SAMPLE, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_hold_and_floors();
    program_envelope(1'b1, 16'd3, 16'd5, 16'h2000, 16'h1000, 16'h4000, 16'h3000);
    send_flags(ACT_SAMPLE, 1'b1, 1'b1, 1'b0);
    send_flags(ACT_SAMPLE, 1'b1, 1'b1, 1'b0);
    // Onset on a begin-block item must be ignored.
    send_flags(ACT_BEGIN, 1'b1, 1'b1, 1'b1);
    repeat (6) send_flags(ACT_SAMPLE, 1'b0, 1'b0, 1'b0);
    send_flags(ACT_SAMPLE, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_out_of_range();
    program_envelope(1'b1, '1, '1, '0, '1, '1, '1);
    send_flags(ACT_BEGIN, 1'b1, 1'b1, 1'b0);
    send_flags(ACT_SAMPLE, 1'b1, 1'b1, 1'b0);
    send_flags(ACT_SAMPLE, 1'b0, 1'b1, 1'b1);
    send_flags(ACT_SAMPLE, 1'b0, 1'b1, 1'b0);
    send_flags(ACT_SAMPLE, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_enable_off();
    program_envelope(1'b0, 16'd8, 16'd8, UNITY, UNITY, '0, '0);
    send_flags(ACT_BEGIN, 1'b1, 1'b1, 1'b0);
    send_flags(ACT_SAMPLE, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_random_traffic();
    int idle_set[4] = '{0, 71, 0, 14};
    int stall_set[4] = '{0, 0, 71, 14};
    int sent;
    int run;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int s = 0; s < 5; s++) begin
        if (s == 0)
          program_envelope(1'b0, '0, '0, CFG_W'(1), CFG_W'(1), '0, '0);
        else if (s == 1)
          program_envelope(1'b1, '1, '1, UNITY, UNITY, UNITY, UNITY);
        else
          program_envelope(1'($urandom_range(1)), pick_hold(), pick_hold(), pick_step(),
                           pick_step(), pick_floor(), pick_floor());
        sent = 0;
        while (sent < 85) begin
          if ($urandom_range(9) == 0) begin
            send_item(in_t'(4'($urandom_range(15))));
            sent++;
          end else begin
            // Well-formed block: a reload followed by a run of samples.
            send_flags(ACT_BEGIN, $urandom_range(3) != 0, $urandom_range(3) != 0,
                       1'($urandom_range(1)));
            sent++;
            run = $urandom_range(1, 30);
            repeat (run) begin
              send_flags(ACT_SAMPLE, $urandom_range(4) != 0, $urandom_range(9) < 7,
                         $urandom_range(9) == 0);
              sent++;
            end
          end
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_unused_index();
    test_hold_and_floors();
    test_out_of_range();
    test_enable_off();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("articulation_gain_envelope test passed");
    end else begin
      $display("articulation_gain_envelope test failed");
    end
    $finish;
  end

endmodule
